// File: rtl/vcs_pkg.sv
package vcs_pkg;

  typedef enum logic [1:0] {
    OP_REFERENCE = 2'd0,
    OP_CONE      = 2'd1,
    OP_SCORE     = 2'd2,
    OP_UNUSED    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_DIR_WEIGHT = 2'd0,
    CFG_SAFE_WEIGHT = 2'd1,
    CFG_EFF_WEIGHT = 2'd2,
    CFG_SPEED_LIMIT = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_VMAG,
    ST_TMAG,
    ST_DMAG,
    ST_DIRMUL,
    ST_DIRDIV,
    ST_DIRW,
    ST_CONE_RD,
    ST_CONE_SUB,
    ST_CONE_MUL,
    ST_CONE_MIN,
    ST_SAFEW,
    ST_EFFDIV,
    ST_EFFW,
    ST_CONTDIV,
    ST_SUM,
    ST_OUT
  } state_t;

  localparam int FRAC_BITS = 12;
  localparam int SCORE_W = 20;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

endpackage

// File: rtl/velocity_candidate_scorer.sv
// Velocity candidate scorer.
// Input channel: in_valid / in_stall, fields operation, vec_a/b/c, is_cone,
// last_candidate. A reference request (operation 0) loads target and current
// velocity and clears cones and the best result. Cone requests (operation 1)
// append to a MAX_CONES-entry cone memory; cones beyond it are dropped and
// flagged. Candidate requests (operation 2) are scored; one marked last emits
// best_vx, best_vy, chosen_score, cones_dropped on out_valid / out_stall.
// Config: cfg_valid / cfg_ready, cfg_index, cfg_data (ready is always high).
// A candidate runs three shared bit-pair square roots, up to three shared
// restoring divisions (the direction one only when candidate and target are
// both nonzero), a read, subtract, multiply and minimum step per stored cone
// and the remaining single steps before the result is registered. The input
// stalls while a candidate is scored.
// The result sits in an output register; if a second result is ready before
// the first is taken, the block holds in its last step and keeps stalling.
// Reset (rst, synchronous) restores register defaults and clears control
// state; the cone memory needs no clearing pass.
module velocity_candidate_scorer
  import vcs_pkg::*;
#(
  parameter int MAX_CONES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic signed [15:0] vec_a_x,
  input  logic signed [15:0] vec_a_y,
  input  logic signed [15:0] vec_b_x,
  input  logic signed [15:0] vec_b_y,
  input  logic signed [15:0] vec_c_x,
  input  logic signed [15:0] vec_c_y,
  input  logic               is_cone,
  input  logic               last_candidate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] best_vx,
  output logic signed [15:0] best_vy,
  output logic signed [19:0] chosen_score,
  output logic               cones_dropped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = (MAX_CONES > 1) ? $clog2(MAX_CONES) : 1;
  localparam int CW = $clog2(MAX_CONES + 1);
  localparam logic [CW-1:0] CONE_MAX = CW'(MAX_CONES);
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int DW = 64;

  logic signed [15:0] dir_w, safe_w, eff_w;
  logic [14:0] speed_lim;

  logic [1:0] cfg_sel;
  assign cfg_ready = 1'b1;
  assign cfg_sel = cfg_index;
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_w <= 16'sd4096;
      safe_w <= 16'sd4096;
      eff_w <= 16'sd4096;
      speed_lim <= 15'd4096;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_sel))
        CFG_DIR_WEIGHT:  dir_w <= cfg_data;
        CFG_SAFE_WEIGHT: safe_w <= cfg_data;
        CFG_EFF_WEIGHT:  eff_w <= cfg_data;
        CFG_SPEED_LIMIT: speed_lim <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic [31:0] vert_mem [MAX_CONES];
  logic [63:0] tan_mem [MAX_CONES];
  logic        type_mem [MAX_CONES];
  logic [31:0] vert_rd;
  logic [63:0] tan_rd;
  logic        type_rd;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vert_mem[mem_wa] <= {vec_a_x, vec_a_y};
      tan_mem[mem_wa] <= {vec_b_x, vec_b_y, vec_c_x, vec_c_y};
      type_mem[mem_wa] <= is_cone;
    end
    vert_rd <= vert_mem[mem_ra];
    tan_rd <= tan_mem[mem_ra];
    type_rd <= type_mem[mem_ra];
  end

  state_t state, state_next;
  logic [CW-1:0] cone_count;
  logic overflow;
  logic signed [15:0] tgt_x, tgt_y, cur_x, cur_y, cand_x, cand_y;
  logic tgt_nz, cand_last;
  logic signed [15:0] best_x, best_y;
  logic signed [19:0] best_val;
  logic have_best;
  logic [CW-1:0] idx;

  // shared square root
  logic [33:0] sq_n, sq_r, sq_bit;
  logic sq_busy;
  // shared divider: quotient of unsigned 64/64
  logic [DW-1:0] dv_num, dv_den, dv_q, dv_rem;
  logic [6:0] dv_cnt;
  logic dv_busy;

  logic [16:0] vmag, tmag, dmag;
  logic signed [33:0] dot;
  logic dot_neg;
  logic signed [47:0] mul_a;
  logic signed [31:0] term_dir, term_safe, term_eff;
  logic signed [33:0] crs_l, crs_r;
  logic signed [16:0] rel_x, rel_y;
  logic any_cone;
  logic [21:0] mind;
  logic started;

  logic [33:0] sq_trial;
  assign sq_trial = sq_r + sq_bit;

  logic [DW:0] dv_shift;
  assign dv_shift = {dv_rem, dv_num[DW-1]};

  logic out_full;
  logic accept;
  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = out_full;

  function automatic logic [33:0] sq_sum(input logic signed [16:0] x,
                                         input logic signed [16:0] y);
    logic signed [33:0] xx, yy;
    xx = 34'(x) * 34'(x);
    yy = 34'(y) * 34'(y);
    return 34'(xx + yy);
  endfunction

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_wa = cone_count[AW-1:0];
    mem_ra = idx[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(operation))
            OP_CONE: mem_we = (cone_count < CONE_MAX);
            OP_SCORE: state_next = ST_VMAG;
            default: ;
          endcase
        end
      end
      ST_VMAG: if (!sq_busy && started) state_next = ST_TMAG;
      ST_TMAG: if (!sq_busy && started) state_next = ST_DMAG;
      ST_DMAG: if (!sq_busy && started) state_next = ST_DIRMUL;
      ST_DIRMUL: state_next = (vmag != 0 && tgt_nz) ? ST_DIRDIV : ST_CONE_RD;
      ST_DIRDIV: if (!dv_busy && started) state_next = ST_DIRW;
      ST_DIRW: state_next = ST_CONE_RD;
      ST_CONE_RD: state_next = (idx < cone_count) ? ST_CONE_SUB : ST_SAFEW;
      ST_CONE_SUB: state_next = ST_CONE_MUL;
      ST_CONE_MUL: state_next = ST_CONE_MIN;
      ST_CONE_MIN: state_next = ST_CONE_RD;
      ST_SAFEW: state_next = ST_EFFDIV;
      ST_EFFDIV: if (!dv_busy && started) state_next = ST_EFFW;
      ST_EFFW: state_next = ST_CONTDIV;
      ST_CONTDIV: if (!dv_busy && started) state_next = ST_SUM;
      ST_SUM: state_next = ST_OUT;
      ST_OUT: state_next = (cand_last && out_full) ? ST_OUT : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic signed [35:0] total;
  logic [14:0] lim;
  assign lim = (speed_lim == 0) ? 15'd1 : speed_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cone_count <= '0;
      overflow <= 1'b0;
      tgt_x <= '0; tgt_y <= '0; tgt_nz <= 1'b0;
      cur_x <= '0; cur_y <= '0;
      best_x <= '0; best_y <= '0;
      best_val <= SCORE_MIN;
      have_best <= 1'b0;
      out_full <= 1'b0;
      sq_busy <= 1'b0;
      dv_busy <= 1'b0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (out_full && !out_stall) out_full <= 1'b0;
      if (state_next != state) started <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (op_t'(operation))
              OP_REFERENCE: begin
                tgt_x <= vec_a_x; tgt_y <= vec_a_y;
                tgt_nz <= (vec_a_x != 0) || (vec_a_y != 0);
                cur_x <= vec_b_x; cur_y <= vec_b_y;
                cone_count <= '0; overflow <= 1'b0;
                best_x <= '0; best_y <= '0;
                best_val <= SCORE_MIN; have_best <= 1'b0;
              end
              OP_CONE: begin
                if (cone_count < CONE_MAX) cone_count <= cone_count + 1'b1;
                else overflow <= 1'b1;
              end
              OP_SCORE: begin
                cand_x <= vec_a_x; cand_y <= vec_a_y;
                cand_last <= last_candidate;
                term_dir <= '0;
                any_cone <= 1'b0;
                idx <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_VMAG, ST_TMAG, ST_DMAG: begin
          if (!started) begin
            started <= 1'b1;
            sq_busy <= 1'b1;
            sq_r <= '0;
            sq_bit <= 34'h1 << 32;
            unique case (state)
              ST_VMAG: sq_n <= sq_sum(17'(cand_x), 17'(cand_y));
              ST_TMAG: sq_n <= sq_sum(17'(tgt_x), 17'(tgt_y));
              default: sq_n <= sq_sum(17'(cand_x) - 17'(cur_x), 17'(cand_y) - 17'(cur_y));
            endcase
          end else if (sq_busy) begin
            if (sq_bit == 0) begin
              sq_busy <= 1'b0;
              unique case (state)
                ST_VMAG: vmag <= sq_r[16:0];
                ST_TMAG: tmag <= sq_r[16:0];
                default: dmag <= sq_r[16:0];
              endcase
            end else begin
              if (sq_n >= sq_trial) begin
                sq_n <= sq_n - sq_trial;
                sq_r <= (sq_r >> 1) + sq_bit;
              end else begin
                sq_r <= sq_r >> 1;
              end
              sq_bit <= sq_bit >> 2;
            end
          end
        end
        ST_DIRMUL: begin
          dot <= 34'(32'(cand_x) * 32'(tgt_x)) + 34'(32'(cand_y) * 32'(tgt_y));
          mul_a <= 48'(34'(vmag) * 34'(tmag));
        end
        ST_DIRDIV, ST_EFFDIV, ST_CONTDIV: begin
          if (!started) begin
            started <= 1'b1;
            dv_busy <= 1'b1;
            dv_cnt <= 7'd64;
            dv_rem <= '0;
            dv_q <= '0;
            unique case (state)
              ST_DIRDIV: begin
                dot_neg <= dot[33];
                dv_num <= DW'(dot[33] ? -dot : dot) << FRAC_BITS;
                dv_den <= DW'(mul_a);
              end
              ST_EFFDIV: begin
                dv_num <= DW'(vmag) << FRAC_BITS;
                dv_den <= DW'(lim);
              end
              default: begin
                dv_num <= DW'(ONE_I) * DW'(ONE_I) / 2;
                dv_den <= DW'(ONE_I) + DW'(dmag);
              end
            endcase
          end else if (dv_busy) begin
            if (dv_cnt == 0) begin
              dv_busy <= 1'b0;
            end else begin
              dv_cnt <= dv_cnt - 1'b1;
              dv_num <= {dv_num[DW-2:0], 1'b0};
              if (dv_shift >= {1'b0, dv_den}) begin
                dv_rem <= DW'(dv_shift - {1'b0, dv_den});
                dv_q <= {dv_q[DW-2:0], 1'b1};
              end else begin
                dv_rem <= dv_shift[DW-1:0];
                dv_q <= {dv_q[DW-2:0], 1'b0};
              end
            end
          end
        end
        ST_DIRW: begin
          logic signed [13:0] cs;
          cs = (dv_q > 64'(ONE_I)) ? 14'(ONE_I) : 14'(dv_q);
          if (dot_neg) cs = -cs;
          term_dir <= 32'((32'(dir_w) * 32'(cs)) / ONE_I);
        end
        ST_CONE_SUB: begin
          rel_x <= 17'(cand_x) - 17'(signed'(vert_rd[31:16]));
          rel_y <= 17'(cand_y) - 17'(signed'(vert_rd[15:0]));
        end
        ST_CONE_MUL: begin
          crs_l <= 34'(signed'(tan_rd[63:48])) * 34'(rel_y)
                 - 34'(signed'(tan_rd[47:32])) * 34'(rel_x);
          crs_r <= 34'(signed'(tan_rd[31:16])) * 34'(rel_y)
                 - 34'(signed'(tan_rd[15:0])) * 34'(rel_x);
        end
        ST_CONE_MIN: begin
          logic [33:0] al, ar, am;
          logic [21:0] d;
          al = crs_l[33] ? 34'(-crs_l) : 34'(crs_l);
          ar = crs_r[33] ? 34'(-crs_r) : 34'(crs_r);
          am = (al < ar) ? al : ar;
          d = 22'(am >> FRAC_BITS);
          if (type_rd) begin
            if (!any_cone || d < mind) mind <= d;
            any_cone <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        ST_SAFEW: begin
          logic signed [13:0] s;
          s = (any_cone && mind < 22'(ONE_I / 2)) ? 14'(mind << 1) : 14'(ONE_I);
          term_safe <= 32'((32'(safe_w) * 32'(s)) / ONE_I);
        end
        ST_EFFW: begin
          logic signed [29:0] e;
          e = 30'(ONE_I) - 30'(dv_q);
          term_eff <= 32'((46'(eff_w) * 46'(e)) / ONE_I);
        end
        ST_SUM: begin
          total <= 36'(term_dir) + 36'(term_safe) + 36'(term_eff) + 36'(dv_q[31:0]);
        end
        ST_OUT: begin
          if (!(cand_last && out_full)) begin
            logic signed [19:0] s;
            logic signed [15:0] bx, by;
            logic hb;
            s = (total > 36'(SCORE_MAX)) ? SCORE_MAX :
                (total < 36'(SCORE_MIN)) ? SCORE_MIN : 20'(total);
            bx = best_x; by = best_y; hb = have_best;
            if (!hb || s > best_val) begin
              best_val <= s; best_x <= cand_x; best_y <= cand_y;
              bx = cand_x; by = cand_y;
              have_best <= 1'b1;
            end
            if (cand_last) begin
              out_full <= 1'b1;
              best_vx <= bx;
              best_vy <= by;
              chosen_score <= (!hb || s > best_val) ? s : best_val;
              cones_dropped <= overflow;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
